// ----- hdl/mppc_pkg.sv -----
// Shared constants and types for the polynomial proportionality checker.
package mppc_pkg;

  localparam int unsigned MOD_BITS = 31;
  localparam logic [MOD_BITS-1:0] MOD_RESET = 31'h7FFF_FFFF;
  localparam logic [MOD_BITS-1:0] MOD_MIN = 31'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_C,
    ST_RED_R,
    ST_EVAL,
    ST_POW_CHK,
    ST_POW_M,
    ST_POW_S,
    ST_SCALE,
    ST_CHK,
    ST_VERIFY,
    ST_FIN
  } eng_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

// ----- hdl/modp_poly_proportional_check.sv -----
// Top level: tests two streamed polynomials over GF(p) for proportionality.
// Per pair: two reductions mod p and, once a scale is known with no mismatch, the check
//   product, all on one bit-serial modular multiplier of XW = max(COEFF_BITS, 31) bits.
// The first pair with a nonzero coefficient adds the Fermat inverse if both of its coefficients
//   are nonzero: up to 62 products on that multiplier. Throughput is set by that shared multiplier.
// A two-entry queue takes pairs while the back end works; the result waits in an output register.
// Reset (rst_n, synchronous, active low): p = 2^31-1, state cleared, queue empty.
module modp_poly_proportional_check #(
  parameter int unsigned COEFF_BITS = 31
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mppc_pkg::MOD_BITS-1:0]        cfg_data,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // cur_coeff, ref_coeff, zero fill
  input  logic [((2*COEFF_BITS+7)/8)*8-1:0]    in_tdata,
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // is_proportional, scale_factor
  output logic [31:0]                          out_tdata
);

  localparam int unsigned CB = COEFF_BITS;
  localparam int unsigned MB = mppc_pkg::MOD_BITS;
  localparam int unsigned XW = (CB > MB) ? CB : MB;
  localparam int unsigned QW = 2 * CB + 1;

  logic [MB-1:0] p_r;
  logic [MB-1:0] p_act;
  logic          q_full;
  logic          q_valid;
  logic [QW-1:0] q_head;
  logic [1:0]    q_cnt;
  logic          q_pop;
  logic          mul_start;
  logic [XW-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic [MB-1:0] mul_res;
  mppc_pkg::mm_stat_t mul_stat;
  logic          res_prop;
  logic [MB-1:0] res_scale;

  assign cfg_ready = 1'b1;
  assign p_act     = (p_r < mppc_pkg::MOD_MIN) ? mppc_pkg::MOD_MIN : p_r;
  assign in_tready = !q_full;
  assign out_tdata = {res_scale, res_prop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= mppc_pkg::MOD_RESET;
    end else if (cfg_valid) begin
      p_r <= cfg_data;
    end
  end

  mppc_queue #(.QW(QW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_tvalid),
    .push_data  ({in_tlast, in_tdata[2*CB-1:0]}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head),
    .cnt        (q_cnt)
  );

  mppc_mulmod #(.XW(XW)) u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (p_act),
    .stat  (mul_stat),
    .res   (mul_res)
  );

  mppc_engine #(.CB(CB), .XW(XW)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .p_act     (p_act),
    .q_valid   (q_valid),
    .q_cur     (q_head[CB-1:0]),
    .q_ref     (q_head[2*CB-1:CB]),
    .q_last    (q_head[2*CB]),
    .q_pop     (q_pop),
    .mul_start (mul_start),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .mul_stat  (mul_stat),
    .mul_res   (mul_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_prop  (res_prop),
    .out_fac   (res_scale)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_cnt != 2'd0))
    else $error("pop from empty queue");

  a_ready_vs_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (q_cnt == 2'd2))
    else $error("input stalled with queue space");

  a_mul_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier restarted while busy");

  a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_scale < p_act))
    else $error("scale not reduced");

endmodule

// ----- hdl/mppc_queue.sv -----
// Front queue: two-entry FIFO of accepted coefficient pairs.
module mppc_queue #(
  parameter int unsigned QW = 63
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [QW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output logic [QW-1:0] head_data,
  output logic [1:0]    cnt
);

  logic [QW-1:0] mem_r [2];
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = mem_r[rp_r];
  assign cnt        = cnt_r;
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- hdl/mppc_mulmod.sv -----
// Bit-serial modular multiplier: res = a * b mod p, one bit of a per cycle.
module mppc_mulmod #(
  parameter int unsigned XW = 31
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [XW-1:0]                a,
  input  logic [mppc_pkg::MOD_BITS-1:0] b,
  input  logic [mppc_pkg::MOD_BITS-1:0] p,
  output mppc_pkg::mm_stat_t           stat,
  output logic [mppc_pkg::MOD_BITS-1:0] res
);

  localparam int unsigned MB = mppc_pkg::MOD_BITS;
  localparam int unsigned CW = $clog2(XW + 1);

  logic [XW-1:0] a_r;
  logic [MB-1:0] b_r;
  logic [MB-1:0] acc_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [MB+1:0] t1;
  logic [MB+1:0] t2;
  logic [MB+1:0] p_x;

  always_comb begin
    p_x = {2'b00, p};
    t1  = {1'b0, acc_r, 1'b0};
    if (t1 >= p_x) begin
      t1 = t1 - p_x;
    end
    t2 = t1 + (a_r[XW-1] ? {2'b00, b_r} : '0);
    if (t2 >= p_x) begin
      t2 = t2 - p_x;
    end
  end

  assign res       = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      a_r   <= {a_r[XW-2:0], 1'b0};
      acc_r <= t2[MB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(XW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/mppc_engine.sv -----
// Back end: reduces pairs, derives the scale by Fermat inverse, checks, emits the verdict.
module mppc_engine #(
  parameter int unsigned CB = 31,
  parameter int unsigned XW = 31
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mppc_pkg::MOD_BITS-1:0] p_act,
  input  logic                          q_valid,
  input  logic [CB-1:0]                 q_cur,
  input  logic [CB-1:0]                 q_ref,
  input  logic                          q_last,
  output logic                          q_pop,
  output logic                          mul_start,
  output logic [XW-1:0]                 mul_a,
  output logic [mppc_pkg::MOD_BITS-1:0] mul_b,
  input  mppc_pkg::mm_stat_t            mul_stat,
  input  logic [mppc_pkg::MOD_BITS-1:0] mul_res,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_prop,
  output logic [mppc_pkg::MOD_BITS-1:0] out_fac
);

  localparam int unsigned MB = mppc_pkg::MOD_BITS;
  localparam logic [MB-1:0] ONE = MB'(1);

  mppc_pkg::eng_state_t st_r, st_nxt;

  logic [CB-1:0] rraw_r;
  logic          last_r;
  logic [MB-1:0] c_r;
  logic [MB-1:0] r_r;
  logic [MB-1:0] acc_r;
  logic [MB-1:0] base_r;
  logic [MB-1:0] exp_r;
  logic [MB-1:0] scale_r;
  logic          seen_r;
  logic          mism_r;
  logic          outv_r;
  logic          prop_r;
  logic [MB-1:0] oscale_r;
  logic          out_free;
  logic          first_nz;
  logic          both_nz;

  assign out_free  = !outv_r || out_ready;
  assign first_nz  = !seen_r && ((c_r != '0) || (r_r != '0));
  assign both_nz   = (c_r != '0) && (r_r != '0);
  assign out_valid = outv_r;
  assign out_prop  = prop_r;
  assign out_fac   = oscale_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      mppc_pkg::ST_IDLE:    if (q_valid) st_nxt = mppc_pkg::ST_RED_C;
      mppc_pkg::ST_RED_C:   if (mul_stat.done) st_nxt = mppc_pkg::ST_RED_R;
      mppc_pkg::ST_RED_R:   if (mul_stat.done) st_nxt = mppc_pkg::ST_EVAL;
      mppc_pkg::ST_EVAL: begin
        st_nxt = (first_nz && both_nz) ? mppc_pkg::ST_POW_CHK : mppc_pkg::ST_CHK;
      end
      mppc_pkg::ST_POW_CHK: begin
        if (exp_r == '0) begin
          st_nxt = mppc_pkg::ST_SCALE;
        end else if (exp_r[0]) begin
          st_nxt = mppc_pkg::ST_POW_M;
        end else begin
          st_nxt = mppc_pkg::ST_POW_S;
        end
      end
      mppc_pkg::ST_POW_M:   if (mul_stat.done) st_nxt = mppc_pkg::ST_POW_S;
      mppc_pkg::ST_POW_S:   if (mul_stat.done) st_nxt = mppc_pkg::ST_POW_CHK;
      mppc_pkg::ST_SCALE:   if (mul_stat.done) st_nxt = mppc_pkg::ST_CHK;
      mppc_pkg::ST_CHK: begin
        st_nxt = (seen_r && !mism_r) ? mppc_pkg::ST_VERIFY : mppc_pkg::ST_FIN;
      end
      mppc_pkg::ST_VERIFY:  if (mul_stat.done) st_nxt = mppc_pkg::ST_FIN;
      mppc_pkg::ST_FIN: begin
        if (!last_r || out_free) st_nxt = mppc_pkg::ST_IDLE;
      end
      default:              st_nxt = mppc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = ONE;
    case (st_r)
      mppc_pkg::ST_IDLE: begin
        q_pop     = q_valid;
        mul_start = q_valid;
        mul_a     = XW'(q_cur);
      end
      mppc_pkg::ST_RED_C: begin
        mul_start = mul_stat.done;
        mul_a     = XW'(rraw_r);
      end
      mppc_pkg::ST_POW_CHK: begin
        mul_start = 1'b1;
        if (exp_r == '0) begin
          mul_a = XW'(r_r);
          mul_b = acc_r;
        end else if (exp_r[0]) begin
          mul_a = XW'(acc_r);
          mul_b = base_r;
        end else begin
          mul_a = XW'(base_r);
          mul_b = base_r;
        end
      end
      mppc_pkg::ST_POW_M: begin
        mul_start = mul_stat.done;
        mul_a     = XW'(base_r);
        mul_b     = base_r;
      end
      mppc_pkg::ST_CHK: begin
        mul_start = seen_r && !mism_r;
        mul_a     = XW'(c_r);
        mul_b     = scale_r;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (st_r)
      mppc_pkg::ST_IDLE: begin
        if (q_valid) begin
          rraw_r <= q_ref;
          last_r <= q_last;
        end
      end
      mppc_pkg::ST_RED_C: if (mul_stat.done) c_r <= mul_res;
      mppc_pkg::ST_RED_R: if (mul_stat.done) r_r <= mul_res;
      mppc_pkg::ST_EVAL: begin
        acc_r  <= ONE;
        base_r <= c_r;
        exp_r  <= p_act - MB'(2);
      end
      mppc_pkg::ST_POW_M: if (mul_stat.done) acc_r <= mul_res;
      mppc_pkg::ST_POW_S: begin
        if (mul_stat.done) begin
          base_r <= mul_res;
          exp_r  <= exp_r >> 1;
        end
      end
      default: begin
        last_r <= last_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= mppc_pkg::ST_IDLE;
      seen_r   <= 1'b0;
      mism_r   <= 1'b0;
      scale_r  <= ONE;
      outv_r   <= 1'b0;
      prop_r   <= 1'b0;
      oscale_r <= ONE;
    end else begin
      st_r <= st_nxt;
      if (outv_r && out_ready) begin
        outv_r <= 1'b0;
      end
      case (st_r)
        mppc_pkg::ST_EVAL: begin
          if (first_nz) begin
            seen_r <= 1'b1;
            if (!both_nz) begin
              mism_r <= 1'b1;
            end
          end
        end
        mppc_pkg::ST_SCALE: if (mul_stat.done) scale_r <= mul_res;
        mppc_pkg::ST_VERIFY: begin
          if (mul_stat.done && (mul_res != r_r)) begin
            mism_r <= 1'b1;
          end
        end
        mppc_pkg::ST_FIN: begin
          if (last_r && out_free) begin
            outv_r   <= 1'b1;
            prop_r   <= !mism_r;
            oscale_r <= scale_r;
            seen_r   <= 1'b0;
            mism_r   <= 1'b0;
            scale_r  <= ONE;
          end
        end
        default: begin
          seen_r <= seen_r;
        end
      endcase
    end
  end

endmodule
